// ===== hw/rtl/tcc_pkg.sv =====
// tcc_pkg: types, register codes and constants of the tile color classifier
// used by every module of the block; depends on nothing

package tcc_pkg;

  localparam int MAX_TILE_PIXELS_DEF = 4096;
  localparam int NUM_REFS_DEF        = 5;

  localparam int PIX_W      = 8;
  localparam int FRAC_W     = 4;
  localparam int AVG_W      = 12;
  localparam int DIST_W     = 14;
  localparam int CODE_W     = 8;
  localparam int DIV_STEPS  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 44;
  localparam int MATCH_W    = 3;
  localparam int THRESH_W   = 36;

  localparam logic [CFG_IDX_W-1:0] REG_REF_END = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd6;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 36'd41073967920;
  localparam logic [CODE_W-1:0]   FIRST_DARK_CODE = 8'd111;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [AVG_W-1:0]  blue;
    logic [AVG_W-1:0]  green;
    logic [AVG_W-1:0]  red;
  } ref_t;

  typedef struct packed {
    logic [AVG_W-1:0] total;
    logic [AVG_W-1:0] elem;
    logic [AVG_W-1:0] dark;
  } thresh_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             tile_end;
  } pixel_t;

  typedef struct packed {
    logic [CODE_W-1:0]  tile_byte;
    logic               byte_valid;
    logic [MATCH_W-1:0] match_index;
    logic               is_dark;
    logic               maybe_new_texture;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic step;
    logic first_chan;
    logic last_chan;
    logic first_ref;
  } l1_ctrl_t;

endpackage

// ===== hw/rtl/tcc_cfg_regs.sv =====
// tcc_cfg_regs: reference colors, mode bit and thresholds of the classifier
// depends on tcc_pkg

module tcc_cfg_regs import tcc_pkg::*; #(
  parameter int NUM_REFS = NUM_REFS_DEF,
  parameter int RIDX_W   = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ref_t                  refs [NUM_REFS],
  output logic                  detect_enable,
  output thresh_t               thresholds
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REFS; i++) begin
        refs[i] <= '0;
      end
      detect_enable <= 1'b0;
      thresholds    <= THRESH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index < CFG_IDX_W'(NUM_REFS) && cfg_index < REG_REF_END) begin
        refs[cfg_index[RIDX_W-1:0]] <= cfg_data;
      end else if (cfg_index == REG_DETECT) begin
        detect_enable <= cfg_data[0];
      end else if (cfg_index == REG_THRESH) begin
        thresholds <= cfg_data[THRESH_W-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/tcc_divider.sv =====
// tcc_divider: restoring divider, one quotient bit a cycle, for sum*16/count
// depends on tcc_pkg

module tcc_divider import tcc_pkg::*; #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0] count,
  output div_status_t      status,
  output logic [AVG_W-1:0] quotient
);

  localparam int REM_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic [REM_W-1:0]  rem;
  logic [AVG_W-1:0]  q;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign trial = {rem[REM_W-2:0], q[AVG_W-1]};
  assign ge    = trial >= {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= REM_W'(sum >> PIX_W);
      q   <= {sum[PIX_W-1:0], {FRAC_W{1'b0}}};
    end else if (busy) begin
      rem <= ge ? trial - {1'b0, count} : trial;
      q   <= {q[AVG_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = q;

endmodule

// ===== hw/rtl/tcc_l1_unit.sv =====
// tcc_l1_unit: shared abs-difference accumulator and nearest reference tracking
// depends on tcc_pkg

module tcc_l1_unit import tcc_pkg::*; #(
  parameter int RIDX_W = 3
) (
  input  logic              clk,
  input  l1_ctrl_t          ctrl,
  input  logic [RIDX_W-1:0] ref_idx,
  input  logic [AVG_W-1:0]  ref_chan,
  input  logic [CODE_W-1:0] ref_code,
  input  logic [AVG_W-1:0]  avg,
  input  logic [AVG_W-1:0]  elem,
  output logic [DIST_W-1:0] best_d,
  output logic [RIDX_W-1:0] best_i,
  output logic [CODE_W-1:0] best_code,
  output logic              best_over
);

  logic [DIST_W-1:0] acc;
  logic              over;
  logic [AVG_W-1:0]  diff;
  logic [DIST_W-1:0] acc_sum;
  logic              over_now;

  assign diff     = (ref_chan > avg) ? ref_chan - avg : avg - ref_chan;
  assign acc_sum  = (ctrl.first_chan ? '0 : acc) + DIST_W'(diff);
  assign over_now = (!ctrl.first_chan && over) || (diff > elem);

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      acc  <= acc_sum;
      over <= over_now;
      if (ctrl.last_chan && (ctrl.first_ref || acc_sum < best_d)) begin
        best_d    <= acc_sum;
        best_i    <= ref_idx;
        best_code <= ref_code;
        best_over <= over_now;
      end
    end
  end

endmodule

// ===== hw/rtl/tile_color_classifier_unit.sv =====
// tile_color_classifier_unit: top level, pixel summing and tile-end sequencer
// depends on tcc_pkg, tcc_cfg_regs, tcc_divider, tcc_l1_unit

// Pixels of a tile stream in at one per cycle and are summed per channel;
// pixels beyond MAX_TILE_PIXELS in a tile are dropped. The pixel marked
// tile_end starts the classification, during which pixel_stall is high: the
// three channel averages go one after another through a shared 12-step
// restoring divider, then one shared abs-difference unit walks the
// references, one channel per cycle, and a final step loads the result
// register; dark tiles skip the reference walk. A result that is held by
// result_stall keeps the block in that final step. The configuration port
// is always ready; write it only while the block is idle.

module tile_color_classifier_unit import tcc_pkg::*; #(
  parameter int MAX_TILE_PIXELS = MAX_TILE_PIXELS_DEF,
  parameter int NUM_REFS        = NUM_REFS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_TILE_PIXELS + 1);
  localparam int SUM_W  = PIX_W + $clog2(MAX_TILE_PIXELS);
  localparam int RIDX_W = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;

  state_t            state;
  state_t            state_next;
  logic [SUM_W-1:0]  sum_red;
  logic [SUM_W-1:0]  sum_green;
  logic [SUM_W-1:0]  sum_blue;
  logic [CNT_W-1:0]  pixel_count;
  logic [1:0]        chan;
  logic [RIDX_W-1:0] ref_idx;
  logic [AVG_W-1:0]  avg [3];
  logic              dark_any;
  logic              first_dark_pending;
  result_t           result_next;

  ref_t              refs [NUM_REFS];
  logic              detect_enable;
  thresh_t           thresholds;

  logic              pixel_take;
  logic              div_start;
  logic [SUM_W-1:0]  div_sum;
  div_status_t       div_st;
  logic [AVG_W-1:0]  quotient;
  logic              bright_now;
  l1_ctrl_t          l1_ctrl;
  ref_t              cur_ref;
  logic [AVG_W-1:0]  ref_chan;
  logic [DIST_W-1:0] best_d;
  logic [RIDX_W-1:0] best_i;
  logic [CODE_W-1:0] best_code;
  logic              best_over;
  logic              finish_go;
  logic              is_dark;

  assign cfg_ready = 1'b1;

  tcc_cfg_regs #(
    .NUM_REFS (NUM_REFS),
    .RIDX_W   (RIDX_W)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .refs          (refs),
    .detect_enable (detect_enable),
    .thresholds    (thresholds)
  );

  tcc_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (div_sum),
    .count    (pixel_count),
    .status   (div_st),
    .quotient (quotient)
  );

  tcc_l1_unit #(
    .RIDX_W (RIDX_W)
  ) u_l1 (
    .clk       (clk),
    .ctrl      (l1_ctrl),
    .ref_idx   (ref_idx),
    .ref_chan  (ref_chan),
    .ref_code  (cur_ref.code),
    .avg       (avg[chan]),
    .elem      (thresholds.elem),
    .best_d    (best_d),
    .best_i    (best_i),
    .best_code (best_code),
    .best_over (best_over)
  );

  assign cur_ref = refs[ref_idx];

  always_comb begin
    case (chan)
      CH_RED:   ref_chan = cur_ref.red;
      CH_GREEN: ref_chan = cur_ref.green;
      default:  ref_chan = cur_ref.blue;
    endcase
    case (chan)
      CH_RED:   div_sum = sum_red;
      CH_GREEN: div_sum = sum_green;
      default:  div_sum = sum_blue;
    endcase
  end

  assign bright_now = dark_any || (quotient > thresholds.dark);
  assign is_dark    = !dark_any;

  always_comb begin
    state_next         = state;
    pixel_stall        = (state != ST_IDLE);
    pixel_take         = pixel_valid && (state == ST_IDLE);
    div_start          = (state == ST_DIV) && !div_st.busy && !div_st.done;
    l1_ctrl.step       = (state == ST_DIST);
    l1_ctrl.first_chan = (chan == CH_RED);
    l1_ctrl.last_chan  = (chan == CH_BLUE);
    l1_ctrl.first_ref  = (ref_idx == '0);
    finish_go          = (state == ST_FINISH) && (!result_valid || !result_stall);
    case (state)
      ST_IDLE: begin
        if (pixel_take && pixel.tile_end) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done && chan == CH_BLUE) begin
          state_next = bright_now ? ST_DIST : ST_FINISH;
        end
      end
      ST_DIST: begin
        if (chan == CH_BLUE && ref_idx == RIDX_W'(NUM_REFS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    result_next.byte_valid        = !detect_enable;
    result_next.is_dark           = is_dark;
    result_next.match_index       = is_dark ? '0 : MATCH_W'(best_i);
    result_next.maybe_new_texture = !is_dark && detect_enable &&
                                    (best_over || best_d > DIST_W'(thresholds.total));
    if (detect_enable) begin
      result_next.tile_byte = '0;
    end else if (is_dark) begin
      result_next.tile_byte = first_dark_pending ? FIRST_DARK_CODE : '0;
    end else begin
      result_next.tile_byte = best_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_red            <= '0;
      sum_green          <= '0;
      sum_blue           <= '0;
      pixel_count        <= '0;
      chan               <= CH_RED;
      ref_idx            <= '0;
      dark_any           <= 1'b0;
      first_dark_pending <= 1'b1;
      result_valid       <= 1'b0;
    end else begin
      if (finish_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pixel_take) begin
            if (pixel_count < CNT_W'(MAX_TILE_PIXELS)) begin
              sum_red     <= sum_red + SUM_W'(pixel.red);
              sum_green   <= sum_green + SUM_W'(pixel.green);
              sum_blue    <= sum_blue + SUM_W'(pixel.blue);
              pixel_count <= pixel_count + 1'b1;
            end
            if (pixel.tile_end) begin
              chan     <= CH_RED;
              dark_any <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            dark_any <= bright_now;
            if (chan == CH_BLUE) begin
              chan    <= CH_RED;
              ref_idx <= '0;
            end else begin
              chan <= chan + 1'b1;
            end
          end
        end
        ST_DIST: begin
          if (chan == CH_BLUE) begin
            chan    <= CH_RED;
            ref_idx <= ref_idx + 1'b1;
          end else begin
            chan <= chan + 1'b1;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            sum_red      <= '0;
            sum_green    <= '0;
            sum_blue     <= '0;
            pixel_count  <= '0;
            if (is_dark && !detect_enable) begin
              first_dark_pending <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_st.done) begin
      avg[chan] <= quotient;
    end
    if (finish_go) begin
      result <= result_next;
    end
  end

endmodule

// ===== hw/rtl/tcc_checker.sv =====
// tcc_checker: port-level checks of the tile color classifier, bound to the top
// depends on tcc_pkg and tile_color_classifier_unit

module tcc_checker import tcc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    pixel_valid,
  input logic    pixel_stall,
  input pixel_t  pixel,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // tile end transfer starts the classification, input is held off
  a_tile_end_stall: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && pixel.tile_end |=> pixel_stall)
    else $error("pixel taken right after tile end");

  a_dark_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_dark |->
      result.match_index == '0 && !result.maybe_new_texture)
    else $error("dark tile with match or texture flag");

  a_normal_no_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_valid |-> !result.maybe_new_texture)
    else $error("texture flag in normal mode");

  a_detect_no_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.byte_valid |-> result.tile_byte == '0)
    else $error("byte value in detect mode");

endmodule

bind tile_color_classifier_unit tcc_checker u_tcc_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .pixel        (pixel),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
